>>> rtl/asps_pkg.sv
// ----------------------------------------------------------------------------
// asps_pkg: shared types and constants of the arrive steering particle step
// Register indexes, sequencer states and reset values.
// ----------------------------------------------------------------------------
package asps_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF   = 8;

  localparam logic [1:0] REG_MASS   = 2'd0;
  localparam logic [1:0] REG_MAXSPD = 2'd1;
  localparam logic [1:0] REG_MAXFRC = 2'd2;
  localparam logic [1:0] REG_RADIUS = 2'd3;

  localparam logic [15:0] MASS_RST   = 16'd256;
  localparam logic [15:0] MAXSPD_RST = 16'd2560;
  localparam logic [15:0] MAXFRC_RST = 16'd154;
  localparam logic [22:0] RADIUS_RST = 23'd51200;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_SQRT1,
    ST_SPD_MUL,
    ST_SPD_DIV,
    ST_DESX_MUL,
    ST_DESX_DIV,
    ST_DESY_MUL,
    ST_DESY_DIV,
    ST_STEER,
    ST_SSX,
    ST_SSY,
    ST_LIMCHK,
    ST_SQRT2,
    ST_LIMX_MUL,
    ST_LIMX_DIV,
    ST_LIMY_MUL,
    ST_LIMY_DIV,
    ST_ADDF,
    ST_AX_DIV,
    ST_AY_DIV,
    ST_UPD,
    ST_OUT
  } state_t;

endpackage

>>> rtl/arrive_steering_particle_step.sv
// ----------------------------------------------------------------------------
// arrive_steering_particle_step: one arrive steering step per frame
// Sequenced datapath with one shared multiplier and one shared
// restoring divide / square root unit.
// ----------------------------------------------------------------------------
// Usage. Each beat on the in_ channel is one animation frame carrying the
// target point and an external force (tdata, low bits first: target_x,
// target_y, ext_force_x, ext_force_y). The block updates its internal
// position and velocity and offers one beat on the out_ channel (tdata:
// new_pos_x, new_pos_y, new_vel_x, new_vel_y).
// The cfg_ channel writes mass, max_speed, max_force and slow_down_radius
// by index 0..3; other indexes are dropped. Write only while idle.
// The frame time is set by the divide and square root unit, which retires
// one quotient or root bit per cycle and is used up to nine times per frame
// (two roots, seven divisions).
// in_tready is high whenever the sequencer is idle. A finished result waits
// in the output register while the next frame is worked on; the sequencer
// holds its last step until that beat is delivered.
// Reset (rst_n low, synchronous) restores the register defaults, places the
// particle at (512.0, 384.0) saturated to the field, and zeroes velocity.
// ----------------------------------------------------------------------------
module arrive_steering_particle_step
  import asps_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // target_x, target_y, ext_force_x, ext_force_y
  input  logic [4*COORD_WIDTH-1:0] in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // new_pos_x, new_pos_y, new_vel_x, new_vel_y
  output logic [4*COORD_WIDTH-1:0] out_tdata,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [22:0]              cfg_data
);

  localparam int W  = COORD_WIDTH;
  // Wide work width: holds squared lengths and products of a magnitude.
  localparam int WW = 2 * W + 2;
  localparam int CW = $clog2(WW + 1);
  localparam logic signed [W+1:0] FMAX = (W+2)'((64'sd1 <<< (W-1)) - 1);
  localparam logic signed [W+1:0] FMIN = -(W+2)'(64'sd1 <<< (W-1));
  localparam logic signed [WW:0]  XMAX = (WW+1)'(FMAX);
  localparam logic signed [WW:0]  XMIN = (WW+1)'(FMIN);
  localparam logic signed [W-1:0] POSX_RST =
    (512 << FRAC_BITS) > ((64'sd1 <<< (W-1)) - 1) ? FMAX[W-1:0] : W'(512 << FRAC_BITS);
  localparam logic signed [W-1:0] POSY_RST =
    (384 << FRAC_BITS) > ((64'sd1 <<< (W-1)) - 1) ? FMAX[W-1:0] : W'(384 << FRAC_BITS);

  state_t state_r, state_nxt;

  logic [15:0] mass_r, maxspd_r, maxfrc_r;
  logic [22:0] radius_r;
  logic signed [W-1:0] px_r, py_r, vx_r, vy_r;
  logic signed [W-1:0] tx_r, ty_r, fx_r, fy_r;
  logic signed [W+1:0] dx_r, dy_r, sx_r, sy_r;
  logic [WW-1:0] acc_r, len_r, spd_r, tmp_r;
  logic [4*W-1:0] out_r;
  logic out_v_r;

  // Shared unit: one multiplier, one bit-serial divider/root.
  logic [W+1:0] mul_a, mul_b;
  logic [2*W+3:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic [WW-1:0] num_r, den_r, quo_r;
  logic [WW:0]   rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, is_sqrt_r, start, start_sqrt;
  logic [WW-1:0] start_num, start_den;
  logic          unit_done;
  logic [WW:0]   trial, rem_sh;
  logic [WW-1:0] root_next;

  function automatic logic [W+1:0] magw(input logic signed [W+1:0] v);
    magw = v[W+1] ? -v : v;
  endfunction

  function automatic logic signed [W+1:0] satw(input logic signed [W+1:0] v);
    if (v > FMAX) satw = FMAX;
    else if (v < FMIN) satw = FMIN;
    else satw = v;
  endfunction

  function automatic logic signed [W-1:0] satn(input logic signed [W+1:0] v);
    logic signed [W+1:0] t;
    t = satw(v);
    satn = t[W-1:0];
  endfunction

  // Velocity update: the acceleration can be far wider than the field.
  function automatic logic signed [W-1:0] sat_acc(input logic signed [WW:0] v);
    if (v > XMAX) sat_acc = FMAX[W-1:0];
    else if (v < XMIN) sat_acc = FMIN[W-1:0];
    else sat_acc = v[W-1:0];
  endfunction

  assign unit_done = busy_r && cnt_r == '0;

  // Restoring step: division shifts one numerator bit in; the root shifts
  // two bits in and trials against 4*root+1.
  always_comb begin
    if (is_sqrt_r) begin
      rem_sh = {rem_r[WW-2:0], num_r[WW-1:WW-2]};
      trial  = rem_sh - {quo_r[WW-2:0], 2'b01};
    end else begin
      rem_sh = {rem_r[WW-1:0], num_r[WW-1]};
      trial  = rem_sh - {1'b0, den_r};
    end
    root_next = {quo_r[WW-2:0], ~trial[WW]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r    <= 1'b1;
      is_sqrt_r <= start_sqrt;
      cnt_r     <= start_sqrt ? CW'(WW / 2) : CW'(WW);
      num_r     <= start_num;
      den_r     <= start_den;
      rem_r     <= '0;
      quo_r     <= '0;
    end else if (busy_r && cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
      num_r <= is_sqrt_r ? {num_r[WW-3:0], 2'b00} : {num_r[WW-2:0], 1'b0};
      rem_r <= trial[WW] ? rem_sh : trial;
      quo_r <= root_next;
    end else if (unit_done) begin
      busy_r <= 1'b0;
    end
  end

  // Handshakes.
  assign in_tready  = state_r == ST_IDLE;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_tvalid && in_tready) state_nxt = ST_DIFF;
      ST_DIFF:     state_nxt = ST_SQX;
      ST_SQX:      state_nxt = ST_SQY;
      ST_SQY:      state_nxt = ST_SQRT1;
      ST_SQRT1:    if (unit_done) state_nxt = (quo_r == '0) ? ST_STEER : ST_SPD_MUL;
      ST_SPD_MUL:  state_nxt = (quo_r < WW'(radius_r)) ? ST_SPD_DIV : ST_DESX_MUL;
      ST_SPD_DIV:  if (unit_done) state_nxt = ST_DESX_MUL;
      ST_DESX_MUL: state_nxt = ST_DESX_DIV;
      ST_DESX_DIV: if (unit_done) state_nxt = ST_DESY_MUL;
      ST_DESY_MUL: state_nxt = ST_DESY_DIV;
      ST_DESY_DIV: if (unit_done) state_nxt = ST_STEER;
      ST_STEER:    state_nxt = ST_SSX;
      ST_SSX:      state_nxt = ST_SSY;
      ST_SSY:      state_nxt = ST_LIMCHK;
      ST_LIMCHK:   state_nxt = (acc_r > tmp_r) ? ST_SQRT2 : ST_ADDF;
      ST_SQRT2:    if (unit_done) state_nxt = ST_LIMX_MUL;
      ST_LIMX_MUL: state_nxt = ST_LIMX_DIV;
      ST_LIMX_DIV: if (unit_done) state_nxt = ST_LIMY_MUL;
      ST_LIMY_MUL: state_nxt = ST_LIMY_DIV;
      ST_LIMY_DIV: if (unit_done) state_nxt = ST_ADDF;
      ST_ADDF:     state_nxt = ST_AX_DIV;
      ST_AX_DIV:   if (unit_done) state_nxt = ST_AY_DIV;
      ST_AY_DIV:   if (unit_done) state_nxt = ST_UPD;
      ST_UPD:      state_nxt = ST_OUT;
      ST_OUT:      if (!out_v_r || out_tready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Unit control and multiplier operands.
  logic [15:0] mdiv;
  assign mdiv = (mass_r == 16'd0) ? 16'd1 : mass_r;

  // Steer plus external force, needed before the register picks it up.
  logic signed [W+1:0] fsum_x;
  assign fsum_x = sx_r + (W+2)'(fx_r);

  always_comb begin
    start      = 1'b0;
    start_sqrt = 1'b0;
    start_num  = '0;
    start_den  = WW'(1);
    mul_a      = '0;
    mul_b      = '0;
    case (state_r)
      ST_SQX: begin
        mul_a = magw(dx_r); mul_b = magw(dx_r);
      end
      ST_SQY: begin
        mul_a = magw(dy_r); mul_b = magw(dy_r);
        start = 1'b1; start_sqrt = 1'b1; start_num = acc_r + mul_p[WW-1:0];
      end
      ST_SPD_MUL: begin
        mul_a = quo_r[W+1:0]; mul_b = (W+2)'(maxspd_r);
        start = quo_r < WW'(radius_r);
        start_num = mul_p[WW-1:0]; start_den = WW'(radius_r);
      end
      ST_DESX_MUL: begin
        mul_a = magw(dx_r); mul_b = spd_r[W+1:0];
        start = 1'b1; start_num = mul_p[WW-1:0]; start_den = len_r;
      end
      ST_DESY_MUL: begin
        mul_a = magw(dy_r); mul_b = spd_r[W+1:0];
        start = 1'b1; start_num = mul_p[WW-1:0]; start_den = len_r;
      end
      ST_STEER: begin
        mul_a = (W+2)'(maxfrc_r); mul_b = (W+2)'(maxfrc_r);
      end
      ST_SSX: begin
        mul_a = magw(sx_r); mul_b = magw(sx_r);
      end
      ST_SSY: begin
        mul_a = magw(sy_r); mul_b = magw(sy_r);
      end
      ST_LIMCHK: begin
        start = acc_r > tmp_r;
        start_sqrt = 1'b1; start_num = acc_r;
      end
      ST_LIMX_MUL: begin
        mul_a = magw(sx_r); mul_b = (W+2)'(maxfrc_r);
        start = 1'b1; start_num = mul_p[WW-1:0]; start_den = len_r;
      end
      ST_LIMY_MUL: begin
        mul_a = magw(sy_r); mul_b = (W+2)'(maxfrc_r);
        start = 1'b1; start_num = mul_p[WW-1:0]; start_den = len_r;
      end
      ST_ADDF: begin
        start = 1'b1; start_num = WW'(magw(fsum_x)) << FRAC_BITS; start_den = WW'(mdiv);
      end
      ST_AX_DIV: begin
        start = unit_done;
        start_num = WW'(magw(sy_r)) << FRAC_BITS; start_den = WW'(mdiv);
      end
      default: ;
    endcase
  end

  // Datapath registers.
  logic signed [W+1:0] qs;
  always_comb qs = (W+2)'(quo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      out_v_r  <= 1'b0;
      mass_r   <= MASS_RST;
      maxspd_r <= MAXSPD_RST;
      maxfrc_r <= MAXFRC_RST;
      radius_r <= RADIUS_RST;
      px_r     <= POSX_RST;
      py_r     <= POSY_RST;
      vx_r     <= '0;
      vy_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MASS:   mass_r   <= cfg_data[15:0];
          REG_MAXSPD: maxspd_r <= cfg_data[15:0];
          REG_MAXFRC: maxfrc_r <= cfg_data[15:0];
          REG_RADIUS: radius_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_v_r && out_tready && state_r != ST_OUT) out_v_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (in_tvalid && in_tready) begin
          tx_r <= in_tdata[W-1:0];
          ty_r <= in_tdata[2*W-1:W];
          fx_r <= in_tdata[3*W-1:2*W];
          fy_r <= in_tdata[4*W-1:3*W];
        end
        ST_DIFF: begin
          dx_r <= satw((W+2)'(tx_r) - (W+2)'(px_r));
          dy_r <= satw((W+2)'(ty_r) - (W+2)'(py_r));
          sx_r <= '0;
          sy_r <= '0;
        end
        ST_SQX: acc_r <= mul_p[WW-1:0];
        ST_SQRT1: if (unit_done) begin
          len_r <= quo_r;
          spd_r <= WW'(maxspd_r);
        end
        ST_SPD_DIV: if (unit_done) spd_r <= quo_r;
        ST_DESX_DIV: if (unit_done) sx_r <= dx_r[W+1] ? -qs : qs;
        ST_DESY_DIV: if (unit_done) sy_r <= dy_r[W+1] ? -qs : qs;
        ST_STEER: begin
          sx_r  <= sx_r - (W+2)'(vx_r);
          sy_r  <= sy_r - (W+2)'(vy_r);
          tmp_r <= mul_p[WW-1:0];
        end
        ST_SSX: acc_r <= mul_p[WW-1:0];
        ST_SSY: acc_r <= acc_r + mul_p[WW-1:0];
        ST_SQRT2: if (unit_done) len_r <= quo_r;
        ST_LIMX_DIV: if (unit_done) sx_r <= sx_r[W+1] ? -qs : qs;
        ST_LIMY_DIV: if (unit_done) sy_r <= sy_r[W+1] ? -qs : qs;
        ST_ADDF: begin
          sx_r <= fsum_x;
          sy_r <= sy_r + (W+2)'(fy_r);
        end
        ST_AX_DIV: if (unit_done) tmp_r <= quo_r;
        ST_AY_DIV: if (unit_done) begin
          vx_r <= sat_acc((WW+1)'(vx_r) + (sx_r[W+1] ? -$signed({1'b0, tmp_r})
                                                     : $signed({1'b0, tmp_r})));
          vy_r <= sat_acc((WW+1)'(vy_r) + (sy_r[W+1] ? -$signed({1'b0, quo_r})
                                                     : $signed({1'b0, quo_r})));
        end
        ST_UPD: begin
          px_r <= satn((W+2)'(px_r) + (W+2)'(vx_r));
          py_r <= satn((W+2)'(py_r) + (W+2)'(vy_r));
        end
        ST_OUT: if (!out_v_r || out_tready) begin
          out_r   <= {vy_r, vx_r, py_r, px_r};
          out_v_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for arrive_steering_particle_step
// Drives frames through the in_ stream and checks every out_ beat against a
// bit-exact software copy of the steering step. Register settings change
// between phases, and both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb;
  import asps_pkg::*;

  localparam int W = COORD_WIDTH_DEF;
  localparam longint FMAX = (64'sd1 <<< (W - 1)) - 1;
  localparam longint FMIN = -(64'sd1 <<< (W - 1));
  localparam int CYCLE_LIMIT = 3000000;
  // Settle time after a drain, long enough to cover any frame still in flight.
  localparam int SETTLE = 500;

  typedef struct packed {
    logic [W-1:0] fy;
    logic [W-1:0] fx;
    logic [W-1:0] ty;
    logic [W-1:0] tx;
  } frame_t;

  typedef struct packed {
    logic [W-1:0] vy;
    logic [W-1:0] vx;
    logic [W-1:0] py;
    logic [W-1:0] px;
  } motion_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [4*W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [4*W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [22:0] cfg_data = '0;

  always #5 clk = ~clk;

  arrive_steering_particle_step DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the block's registers and particle state.
  longint unsigned p_mass, p_speed, p_force, p_radius;
  longint pos_x, pos_y, vel_x, vel_y;

  frame_t  frames_pending[$];
  motion_t motion_expected[$];
  int      errors = 0;
  bit      quiet = 1'b0;

  function automatic longint clamp(longint v);
    if (v > FMAX) return FMAX;
    if (v < FMIN) return FMIN;
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned magn(longint v);
    return $unsigned((v < 0) ? -v : v);
  endfunction

  // v * num / den with truncation toward zero.
  function automatic longint ratio(longint v, longint unsigned num, longint unsigned den);
    longint unsigned q = magn(v) * num / den;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  // One arrive step: updates the shadow state and returns the new motion.
  function automatic motion_t steer_step(frame_t f);
    longint tx, ty, fx, fy, dx, dy, dsx, dsy, sx, sy, ax, ay;
    longint unsigned d_len, spd, ssq, sl, mdiv;
    motion_t m;
    tx = longint'($signed(f.tx));
    ty = longint'($signed(f.ty));
    fx = longint'($signed(f.fx));
    fy = longint'($signed(f.fy));
    dx = clamp(tx - pos_x);
    dy = clamp(ty - pos_y);
    d_len = floor_sqrt(magn(dx) * magn(dx) + magn(dy) * magn(dy));
    dsx = 0;
    dsy = 0;
    // A target that is already reached leaves the desired vector at zero.
    if (d_len != 0) begin
      spd = p_speed;
      if (d_len < p_radius) spd = d_len * p_speed / p_radius;
      dsx = ratio(dx, spd, d_len);
      dsy = ratio(dy, spd, d_len);
    end
    sx = dsx - vel_x;
    sy = dsy - vel_y;
    ssq = magn(sx) * magn(sx) + magn(sy) * magn(sy);
    if (ssq > p_force * p_force) begin
      sl = floor_sqrt(ssq);
      sx = ratio(sx, p_force, sl);
      sy = ratio(sy, p_force, sl);
    end
    mdiv = (p_mass == 0) ? 1 : p_mass;
    ax = ratio(sx + fx, 256, mdiv);
    ay = ratio(sy + fy, 256, mdiv);
    vel_x = clamp(vel_x + ax);
    vel_y = clamp(vel_y + ay);
    pos_x = clamp(pos_x + vel_x);
    pos_y = clamp(pos_y + vel_y);
    m.px = pos_x[W-1:0];
    m.py = pos_y[W-1:0];
    m.vx = vel_x[W-1:0];
    m.vy = vel_y[W-1:0];
    return m;
  endfunction

  // Input driver: each accepted beat is run through the predictor, and the
  // next frame (or an idle burst) is set up.
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) motion_expected.push_back(steer_step(frame_t'(in_tdata)));
      if (in_gap == 0 && !quiet && $urandom_range(0, 5) == 0)
        in_gap = $urandom_range(1, 17);
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (frames_pending.size() > 0) begin
        in_tdata  <= frames_pending.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output monitor with random back-pressure bursts.
  int out_gap = 0;
  always @(posedge clk) begin
    motion_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = motion_t'(out_tdata);
        if (motion_expected.size() == 0) begin
          $error("unexpected result beat %h", out_tdata);
          errors++;
        end else begin
          want = motion_expected.pop_front();
          if (got.px !== want.px) begin
            $error("new_pos_x expected %0d got %0d", $signed(want.px), $signed(got.px));
            errors++;
          end
          if (got.py !== want.py) begin
            $error("new_pos_y expected %0d got %0d", $signed(want.py), $signed(got.py));
            errors++;
          end
          if (got.vx !== want.vx) begin
            $error("new_vel_x expected %0d got %0d", $signed(want.vx), $signed(got.vx));
            errors++;
          end
          if (got.vy !== want.vy) begin
            $error("new_vel_y expected %0d got %0d", $signed(want.vy), $signed(got.vy));
            errors++;
          end
        end
      end
      if (out_gap == 0 && !quiet && $urandom_range(0, 5) == 0)
        out_gap = $urandom_range(1, 17);
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Register write; the 16-bit registers get random upper bits that the
  // block must drop.
  task automatic write_reg(logic [1:0] idx, logic [22:0] val);
    logic [22:0] d;
    d = val;
    if (idx != REG_RADIUS) d[22:16] = 7'($urandom);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= d;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MASS:   p_mass   = 64'(d[15:0]);
      REG_MAXSPD: p_speed  = 64'(d[15:0]);
      REG_MAXFRC: p_force  = 64'(d[15:0]);
      REG_RADIUS: p_radius = 64'(d);
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(int m, int s, int f, int r);
    write_reg(REG_MASS, 23'(m));
    write_reg(REG_MAXSPD, 23'(s));
    write_reg(REG_MAXFRC, 23'(f));
    write_reg(REG_RADIUS, 23'(r));
  endtask

  task automatic drain();
    while (frames_pending.size() > 0 || in_tvalid || motion_expected.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [W-1:0] fld(longint v);
    return v[W-1:0];
  endfunction

  // One frame run to completion, so the target can depend on the position.
  task automatic frame_now(longint tx, longint ty, longint fx, longint fy);
    frame_t f;
    f.tx = fld(tx); f.ty = fld(ty); f.fx = fld(fx); f.fy = fld(fy);
    frames_pending.push_back(f);
    drain();
  endtask

  // Mostly targets near the particle with modest forces, so the arrive and
  // slow-down paths are exercised; the rest use the full field range.
  function automatic frame_t rand_frame();
    frame_t f;
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) begin
      f.tx = fld(clamp(pos_x + $signed($urandom_range(0, 131072)) - 65536));
      f.ty = fld(clamp(pos_y + $signed($urandom_range(0, 131072)) - 65536));
      f.fx = fld(longint'($urandom_range(0, 512)) - 256);
      f.fy = fld(longint'($urandom_range(0, 512)) - 256);
    end else begin
      f.tx = W'($urandom); f.ty = W'($urandom); f.fx = W'($urandom); f.fy = W'($urandom);
    end
    return f;
  endfunction

  task automatic random_phase(int n);
    repeat (n) frames_pending.push_back(rand_frame());
    drain();
  endtask

  initial begin
    p_mass = MASS_RST; p_speed = MAXSPD_RST; p_force = MAXFRC_RST; p_radius = RADIUS_RST;
    pos_x = clamp(512 * 256);
    pos_y = clamp(384 * 256);
    vel_x = 0;
    vel_y = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed frames under the reset settings first.
    frame_now(pos_x, pos_y, 0, 0);                 // target already reached
    frame_now(FMAX, FMAX, 0, 0);                   // far target
    frame_now(FMIN, FMIN, FMAX, FMIN);
    frame_now(FMIN, FMAX, FMIN, FMAX);
    frame_now(pos_x + 100, pos_y - 50, 0, 0);      // inside the slow-down radius
    frame_now(pos_x, pos_y, 3, -3);
    set_regs(0, 65535, 65535, 0);                  // zero mass, zero radius
    frame_now(FMAX, FMIN, FMAX, FMAX);             // velocity and position saturate
    frame_now(FMAX, FMIN, FMAX, FMAX);
    frame_now(FMIN, FMAX, FMIN, FMIN);
    frame_now(pos_x, pos_y, 0, 0);
    set_regs(65535, 0, 0, 8388607);                // no speed, no steering
    frame_now(FMIN, FMIN, 0, 0);
    frame_now(1000, -1000, FMAX, FMIN);
    set_regs(1, 2560, 65535, 1);
    frame_now(pos_x + 1, pos_y, 0, 0);
    frame_now(FMAX, 0, -5, 5);
    frame_now(pos_x, pos_y, 0, 0);
    set_regs(256, 2560, 154, 51200);
    frame_now(0, 0, 0, 0);
    frame_now(pos_x - 300, pos_y + 300, 0, 0);

    // Random phases; the register setting changes between most of them.
    random_phase(200);
    set_regs($urandom_range(1, 65535), $urandom_range(0, 65535),
             $urandom_range(0, 65535), $urandom_range(1, 8388607));
    random_phase(200);
    set_regs(65535, 65535, 65535, 8388607);
    random_phase(150);
    set_regs(1, 0, 0, 1);
    random_phase(150);
    set_regs($urandom_range(64, 1024), $urandom_range(256, 8192),
             $urandom_range(16, 1024), $urandom_range(256, 200000));
    random_phase(200);
    set_regs(0, $urandom_range(0, 65535), $urandom_range(0, 65535), 0);
    random_phase(150);
    set_regs(256, 2560, 154, 51200);
    random_phase(50);
    quiet = 1'b1;                                  // closing stretch at full rate
    random_phase(200);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
